// ===== hw/rtl/positional_list_engine_unit_defines.svh =====
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define PLE_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("positional list engine check failed");

// Check a condition in the cycle after its trigger.
`define PLE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("positional list engine check failed");

`endif

// ===== hw/rtl/pleu_pkg.sv =====
// Package with the command, status and control types of the list engine.
`timescale 1ns / 1ps

package pleu_pkg;

   localparam int CMD_W   = 3;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_FRONT = 3'd0,
      CMD_ADD_REAR  = 3'd1,
      CMD_REM_FRONT = 3'd2,
      CMD_REM_REAR  = 3'd3,
      CMD_INS_AT    = 3'd4,
      CMD_REM_AT    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // Shift control broadcast from the decoder to every cell.
   typedef struct packed {
      logic       ins;
      logic       rem;
      status_type status;
   } op_ctrl_type;

endpackage

// ===== hw/rtl/pleu_if.sv =====
// Request and response channel interfaces of the list engine.
`timescale 1ns / 1ps

interface pleu_req_if
   import pleu_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [POS_W-1:0]   position;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface pleu_rsp_if
   import pleu_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] removed_value;
   status_type         status;
   logic [COUNT_W-1:0] count_now;

   modport source (output valid, output removed_value, output status, output count_now,
                   input ready);
   modport sink   (input valid, input removed_value, input status, input count_now,
                   output ready);
endinterface

// ===== hw/rtl/pleu_cell.sv =====
// One storage cell of the element chain.
`timescale 1ns / 1ps

module pleu_cell
   import pleu_pkg::*;
#(
   parameter int ELEM_WIDTH = 32,
   parameter int IDX_W      = 4,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  enable,
   input  op_ctrl_type           ctrl,
   input  logic [IDX_W-1:0]      idx,
   input  logic [ELEM_WIDTH-1:0] new_value,
   input  logic [ELEM_WIDTH-1:0] left_data,
   input  logic [ELEM_WIDTH-1:0] right_data,
   output logic [ELEM_WIDTH-1:0] data,
   output logic [ELEM_WIDTH-1:0] tap
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [ELEM_WIDTH-1:0] data_ff;
   logic [ELEM_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (MY_IDX > idx) begin
            data_in = left_data;
         end else if (MY_IDX == idx) begin
            data_in = new_value;
         end
      end else if (ctrl.rem) begin
         if (MY_IDX >= idx) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;
   // drive own element onto the removal bus when addressed
   assign tap  = (MY_IDX == idx) ? data_ff : '0;

endmodule

// ===== hw/rtl/pleu_decode.sv =====
// Command decoder: checks the command against the count and picks the shift.
`timescale 1ns / 1ps

module pleu_decode
   import pleu_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic [CMD_W-1:0] cmd,
   input  logic [POS_W-1:0] position,
   input  logic [CNT_W-1:0] count,
   output op_ctrl_type      ctrl,
   output logic [IDX_W-1:0] idx,
   output logic [CNT_W-1:0] count_next
);

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CMP_W-1:0] ONE = CMP_W'(1);

   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] pos_m1;
   logic [CMP_W-1:0] cnt_m1;
   logic             full;
   logic             empty;

   assign pos_w  = CMP_W'(position);
   assign cnt_w  = CMP_W'(count);
   assign pos_m1 = pos_w - ONE;
   assign cnt_m1 = cnt_w - ONE;
   assign full   = (cnt_w >= CMP_W'(CAPACITY));
   assign empty  = (cnt_w == '0);

   always_comb begin
      ctrl.ins    = 1'b0;
      ctrl.rem    = 1'b0;
      ctrl.status = ST_OK;
      idx         = '0;
      unique case (cmd_type'(cmd))
         CMD_ADD_FRONT: begin
            if (full) ctrl.status = ST_FULL;
            else ctrl.ins = 1'b1;
         end
         CMD_ADD_REAR: begin
            idx = cnt_w[IDX_W-1:0];
            if (full) ctrl.status = ST_FULL;
            else ctrl.ins = 1'b1;
         end
         CMD_REM_FRONT: begin
            if (empty) ctrl.status = ST_UNDER;
            else ctrl.rem = 1'b1;
         end
         CMD_REM_REAR: begin
            idx = cnt_m1[IDX_W-1:0];
            if (empty) ctrl.status = ST_UNDER;
            else ctrl.rem = 1'b1;
         end
         CMD_INS_AT: begin
            idx = pos_m1[IDX_W-1:0];
            if (pos_w < ONE || pos_w > cnt_w + ONE) ctrl.status = ST_RANGE;
            else if (full) ctrl.status = ST_FULL;
            else ctrl.ins = 1'b1;
         end
         CMD_REM_AT: begin
            idx = pos_m1[IDX_W-1:0];
            if (pos_w < ONE || pos_w > cnt_w) ctrl.status = ST_RANGE;
            else ctrl.rem = 1'b1;
         end
         default: begin
            ctrl.status = ST_RANGE;
         end
      endcase
   end

   always_comb begin
      count_next = count;
      if (ctrl.ins) begin
         count_next = count + CNT_W'(1);
      end else if (ctrl.rem) begin
         count_next = count - CNT_W'(1);
      end
   end

endmodule

// ===== hw/rtl/positional_list_engine_unit.sv =====
// Top level of the positional list engine: decoder, cell chain, result register.
`timescale 1ns / 1ps
`include "positional_list_engine_unit_defines.svh"

// Usage
// - req_chan carries one command word (cmd, position, value); rsp_chan returns
//   one result word (removed_value, status, count_now) per command, in order.
// - A command is decoded against the current count in the cycle it is taken;
//   every cell of the chain then holds, loads the new value, or copies its
//   left or right neighbor, all in the same clock edge.
// - Latency: the result word is valid the cycle after the command is taken.
// - Throughput: one command per cycle; the result register is the only
//   stage, and a new command is taken whenever that register is empty or is
//   being drained in the same cycle.
// - The removed element comes off a one-hot bus that every cell drives when
//   its index matches, so it is captured into the result register as the command is taken.
// - When the receiver stalls, the result word holds and req_chan.ready drops
//   until the word is taken; the list does not change meanwhile.
// - Reset clears the element count and the result valid flag; cell contents
//   stay as they are and are only ever read once written.
module positional_list_engine_unit
   import pleu_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   pleu_req_if.sink    req_chan,
   pleu_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // element count
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [VALUE_W-1:0] removed_ff;
   logic [VALUE_W-1:0] removed_in;
   status_type         status_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic               accept;
   op_ctrl_type        ctrl;
   op_ctrl_type        cell_ctrl;
   logic [IDX_W-1:0]   idx;
   logic [CNT_W-1:0]   count_next;

   logic [ELEM_WIDTH-1:0] new_value;
   logic [63:0]           value_wide;
   logic [63:0]           removed_wide;
   logic [31:0]           count_wide;

   logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
   logic [ELEM_WIDTH-1:0] cell_tap  [CAPACITY];
   logic [ELEM_WIDTH-1:0] tap_or    [CAPACITY+1];

   // take a word whenever the result slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   pleu_decode #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_decode (
      .cmd        (req_chan.cmd),
      .position   (req_chan.position),
      .count      (occ_ff),
      .ctrl       (ctrl),
      .idx        (idx),
      .count_next (count_next)
   );

   // keep only the low ELEM_WIDTH bits of the incoming value
   assign value_wide = 64'(req_chan.value);
   assign new_value  = value_wide[ELEM_WIDTH-1:0];

   // hold every cell unless a command is actually taken
   always_comb begin
      cell_ctrl     = ctrl;
      cell_ctrl.ins = ctrl.ins && accept;
      cell_ctrl.rem = ctrl.rem && accept;
   end

   assign tap_or[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_data;
      logic [ELEM_WIDTH-1:0] right_data;

      // chain ends feed back their own contents
      if (i == 0) begin : g_first
         assign left_data = cell_data[i];
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      pleu_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .enable     (accept),
         .ctrl       (cell_ctrl),
         .idx        (idx),
         .new_value  (new_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .tap        (cell_tap[i])
      );

      assign tap_or[i+1] = tap_or[i] | cell_tap[i];
   end

   // widen or trim the removed element to the result field
   assign removed_wide = 64'(tap_or[CAPACITY]);
   assign count_wide   = 32'(count_next);

   always_comb begin
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff;
      removed_in   = removed_ff;
      count_in     = count_ff;
      if (accept) begin
         occ_in       = count_next;
         rsp_valid_in = 1'b1;
         removed_in   = ctrl.rem ? removed_wide[VALUE_W-1:0] : '0;
         count_in     = count_wide[COUNT_W-1:0];
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff <= removed_in;
         status_ff  <= ctrl.status;
         count_ff   <= count_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.removed_value = removed_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.count_now     = count_ff;

   // count never passes capacity
   `PLE_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_W'(CAPACITY))
   // a stalled result blocks new commands
   `PLE_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_chan.ready,
                   !req_chan.ready)
   // an accepted command always leaves a result word behind
   `PLE_ASSERT_NEXT(a_accept_result, clock, reset, accept, rsp_valid_ff)
   // the list count moves only on an accepted command
   `PLE_ASSERT_NEXT(a_occ_stable, clock, reset, !accept, $stable(occ_ff))
   // an error result never carries a removed element
   `PLE_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid_ff && status_ff != ST_OK,
                   removed_ff == '0)

endmodule
